// ===== design/spq_pkg.sv =====
package spq_pkg;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  item_prio;
        logic [15:0] item_value;
    } req_t;

    typedef struct packed {
        logic [15:0] out_value;
        logic [7:0]  out_prio;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] value;
    } entry_t;

    // broadcast to every cell for one transfer
    typedef struct packed {
        logic   ins;
        logic   del;
        entry_t item;
    } cell_op_t;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell (
    input  logic             clk,
    input  spq_pkg::cell_op_t op,
    input  logic             occupied,
    input  logic             at_tail,
    input  logic             left_take,
    input  spq_pkg::entry_t  left_entry,
    input  spq_pkg::entry_t  right_entry,
    output logic             take,
    output spq_pkg::entry_t  entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // this slot changes on insert: held entry is outranked, or first free slot
    assign take = (occupied && (entry_reg.prio < op.item.prio)) || at_tail;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins && take)
        begin
            // shift from the left if the neighbor also moved, else land the new item
            entry_next = left_take ? left_entry : op.item;
        end
        else if (op.del)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue built as a row of DEPTH cells, head at cell 0.
// Request channel: req_valid / req_stall / req. req_type selects insert
// (by item_prio, equal priorities keep arrival order) or delete of the head.
// Response channel: rsp_valid / rsp_stall / rsp, one response per request,
// carrying the removed entry (0 otherwise), a status code and the occupancy.
// The response is registered at the edge that takes the request. The queue
// takes one request per cycle while the receiver does not stall; every cell
// compares its own priority with the broadcast item and shifts in its
// neighbor's entry in that same cycle, so no request waits on another.
// When the receiver stalls, the held response stays put and req_stall rises
// until it is taken. Reset empties the queue and sets capacity to 16; the
// entry storage itself is not cleared. cfg_we / cfg_data write the capacity;
// the user writes it only while idle; the block does not enforce it. 0 acts
// as 1 and values above DEPTH act as DEPTH. Inserts beyond capacity report
// full, deletes on an empty queue report empty; neither changes the queue.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  spq_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output spq_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]  cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [spq_pkg::CAP_W-1:0] cap_reg;
    logic                     rsp_valid_reg;
    spq_pkg::rsp_t            rsp_reg;
    spq_pkg::rsp_t            rsp_next;

    logic                     accept;
    logic [WW-1:0]            count_w;
    logic [WW-1:0]            count_next_w;
    logic [WW-1:0]            cap_w;
    logic [WW-1:0]            cap_eff;
    logic                     full;
    logic                     empty;
    spq_pkg::cell_op_t        op;

    logic                     take   [DEPTH];
    spq_pkg::entry_t          entry  [DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign count_w      = WW'(count_reg);
    assign count_next_w = WW'(count_next);
    assign cap_w        = WW'(cap_reg);

    always_comb
    begin
        cap_eff = cap_w;
        if (cap_w == '0)
        begin
            cap_eff = WW'(1);
        end
        else if (cap_w > DEPTH_W)
        begin
            cap_eff = DEPTH_W;
        end
    end

    assign full  = (count_w >= cap_eff) || (count_w >= DEPTH_W);
    assign empty = (count_reg == '0);

    always_comb
    begin
        op.ins  = accept && (req.req_type == spq_pkg::REQ_INSERT) && !full;
        op.del  = accept && (req.req_type == spq_pkg::REQ_DELETE) && !empty;
        op.item.prio  = req.item_prio;
        op.item.value = req.item_value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic            left_take;
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;

            if (gi == 0)
            begin : g_head
                assign left_take  = 1'b0;
                assign left_entry = '0;
            end
            else
            begin : g_body
                assign left_take  = take[gi-1];
                assign left_entry = entry[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_entry = entry[gi];
            end
            else
            begin : g_inner
                assign right_entry = entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .op          (op),
                .occupied    (CW'(gi) < count_reg),
                .at_tail     (CW'(gi) == count_reg),
                .left_take   (left_take),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .take        (take[gi]),
                .entry       (entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rsp_next.out_value = '0;
        rsp_next.out_prio  = '0;
        rsp_next.status    = spq_pkg::STATUS_DONE;
        if (req.req_type == spq_pkg::REQ_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = spq_pkg::STATUS_FULL;
            end
        end
        else if (empty)
        begin
            rsp_next.status = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            rsp_next.out_value = entry[0].value;
            rsp_next.out_prio  = entry[0].prio;
        end
        // report occupancy modulo 32
        rsp_next.occupancy = count_next_w[spq_pkg::CAP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= spq_pkg::CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== sim/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH     = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 90;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    spq_pkg::req_t              req       = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    spq_pkg::rsp_t              rsp;
    logic                       cfg_we    = 1'b0;
    logic [spq_pkg::CAP_W-1:0]  cfg_data  = '0;

    sorted_priority_queue #(
        .DEPTH (QDEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // shadow of the queue contents, head at index 0
    spq_pkg::entry_t            held_entries[$];
    logic [spq_pkg::CAP_W-1:0]  capacity_shadow = spq_pkg::CAP_RESET;

    spq_pkg::req_t     req_backlog[$];
    spq_pkg::rsp_t     owed_rsp[$];

    int                errors       = 0;
    int                cycle_count  = 0;
    int                tx_gap       = 0;
    int                tx_calm      = 0;
    int                rx_left      = 0;
    int                rx_calm      = 0;
    int                holds_asked  = 0;
    int                holds_done   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // apply one request to the shadow queue and return the response it owes
    function automatic spq_pkg::rsp_t serve_request(spq_pkg::req_t r);
        spq_pkg::rsp_t   o;
        spq_pkg::entry_t e;
        int              lim;
        int              pos;
        o   = '0;
        lim = (capacity_shadow == 0) ? 1 :
              ((capacity_shadow > QDEPTH) ? QDEPTH : int'(capacity_shadow));
        if (r.req_type == spq_pkg::REQ_INSERT)
        begin
            if (held_entries.size() >= lim || held_entries.size() >= QDEPTH)
            begin
                o.status = spq_pkg::STATUS_FULL;
            end
            else
            begin
                // land behind every entry of equal or higher priority
                pos = held_entries.size();
                while (pos > 0 && held_entries[pos-1].prio < r.item_prio)
                    pos--;
                e.prio  = r.item_prio;
                e.value = r.item_value;
                held_entries.insert(pos, e);
                o.status = spq_pkg::STATUS_DONE;
            end
        end
        else if (held_entries.size() == 0)
        begin
            o.status = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            e           = held_entries.pop_front();
            o.out_value = e.value;
            o.out_prio  = e.prio;
            o.status    = spq_pkg::STATUS_DONE;
        end
        o.occupancy = 5'(held_entries.size());
        return o;
    endfunction

    // request driver
    always @(posedge clk)
    begin : req_driver
        spq_pkg::req_t nxt;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                owed_rsp.push_back(serve_request(req));
            if (!req_valid || !req_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    nxt = req_backlog.pop_front();
                    req       <= nxt;
                    req_valid <= 1'b1;
                    if (tx_calm > 0)
                    begin
                        tx_calm--;
                        tx_gap = 0;
                    end
                    else
                    begin
                        tx_gap = idle_len();
                        if ($urandom_range(0, 39) == 0)
                            tx_calm = $urandom_range(15, 60);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response stall generator
    always @(posedge clk)
    begin : rsp_staller
        if (holds_done != holds_asked)
        begin
            holds_done++;
            rx_left = LONG_HOLD;
        end
        else if (rx_left == 0)
        begin
            if (rx_calm > 0)
            begin
                rx_calm--;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                rx_calm = $urandom_range(15, 60);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                rx_left = idle_len();
            end
        end
        rsp_stall <= (rx_left > 0);
        if (rx_left > 0)
            rx_left--;
    end

    // response checker
    always @(posedge clk)
    begin : rsp_checker
        spq_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: response transfer with none outstanding: %s",
                         $time, "expected none");
                $display("%0t:   got value=%h prio=%h status=%0d occupancy=%0d",
                         $time, rsp.out_value, rsp.out_prio, rsp.status,
                         rsp.occupancy);
            end
            else
            begin
                want = owed_rsp.pop_front();
                if (rsp.out_value !== want.out_value || rsp.out_prio !== want.out_prio ||
                    rsp.status !== want.status || rsp.occupancy !== want.occupancy)
                begin
                    errors++;
                    $display("%0t: mismatch: expected value=%h prio=%h status=%0d occupancy=%0d",
                             $time, want.out_value, want.out_prio, want.status,
                             want.occupancy);
                    $display("%0t:   got value=%h prio=%h status=%0d occupancy=%0d",
                             $time, rsp.out_value, rsp.out_prio, rsp.status,
                             rsp.occupancy);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_req(logic kind, logic [7:0] prio, logic [15:0] value);
        spq_pkg::req_t r;
        r.req_type   = kind;
        r.item_prio  = prio;
        r.item_value = value;
        req_backlog.push_back(r);
    endtask

    // wait until every request is transferred and every response taken
    task automatic drain();
        do
            @(negedge clk);
        while (req_backlog.size() > 0 || req_valid || owed_rsp.size() > 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_capacity(logic [spq_pkg::CAP_W-1:0] cap);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity_shadow = cap;
        @(negedge clk);
    endtask

    // runs of mostly inserts or mostly deletes so the queue reaches full and empty
    task automatic random_phase(int n);
        int            left;
        int            seg;
        int            ins_pct;
        int            pmode;
        spq_pkg::req_t r;
        left = n;
        while (left > 0)
        begin
            seg = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 20;
                default: ins_pct = 50;
            endcase
            pmode = $urandom_range(0, 3);
            repeat (seg)
            begin
                r.req_type = ($urandom_range(0, 99) < ins_pct) ?
                             spq_pkg::REQ_INSERT : spq_pkg::REQ_DELETE;
                case (pmode)
                    0: r.item_prio = 8'($urandom_range(0, 3));
                    1: r.item_prio = 8'($urandom_range(252, 255));
                    2:
                    begin
                        case ($urandom_range(0, 2))
                            0:       r.item_prio = 8'd0;
                            1:       r.item_prio = 8'd255;
                            default: r.item_prio = 8'($urandom_range(0, 255));
                        endcase
                    end
                    default: r.item_prio = 8'($urandom_range(0, 255));
                endcase
                r.item_value = 16'($urandom_range(0, 65535));
                req_backlog.push_back(r);
                left--;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [spq_pkg::CAP_W-1:0] caps [0:8];
        int                        i;

        caps = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd16,
                 5'($urandom_range(2, 15)), 5'($urandom_range(17, 30)), 5'd16, 5'd12};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty delete, extremes, and equal priorities in arrival order
        push_req(spq_pkg::REQ_DELETE, 8'd0,   16'h0000);
        push_req(spq_pkg::REQ_INSERT, 8'd0,   16'h0000);
        push_req(spq_pkg::REQ_INSERT, 8'd255, 16'hffff);
        push_req(spq_pkg::REQ_INSERT, 8'd255, 16'h1234);
        push_req(spq_pkg::REQ_INSERT, 8'd128, 16'haaaa);
        repeat (5) push_req(spq_pkg::REQ_DELETE, 8'hff, 16'hffff);
        drain();

        set_capacity(5'd1);
        push_req(spq_pkg::REQ_INSERT, 8'd7, 16'h0001);
        push_req(spq_pkg::REQ_INSERT, 8'd9, 16'h0002);
        push_req(spq_pkg::REQ_DELETE, 8'd0, 16'h0000);
        drain();

        // zero capacity behaves as one
        set_capacity(5'd0);
        push_req(spq_pkg::REQ_INSERT, 8'd3,   16'h0003);
        push_req(spq_pkg::REQ_INSERT, 8'd200, 16'h0004);
        push_req(spq_pkg::REQ_DELETE, 8'd0,   16'h0000);
        drain();

        // lower capacity below the occupancy, then work back down
        set_capacity(5'd16);
        push_req(spq_pkg::REQ_INSERT, 8'd10, 16'h0a0a);
        push_req(spq_pkg::REQ_INSERT, 8'd50, 16'h5050);
        push_req(spq_pkg::REQ_INSERT, 8'd10, 16'h0b0b);
        push_req(spq_pkg::REQ_INSERT, 8'd90, 16'h9090);
        drain();
        set_capacity(5'd2);
        push_req(spq_pkg::REQ_INSERT, 8'd99, 16'h6363);
        repeat (3) push_req(spq_pkg::REQ_DELETE, 8'd0, 16'h0000);
        push_req(spq_pkg::REQ_INSERT, 8'd1, 16'h0101);
        push_req(spq_pkg::REQ_INSERT, 8'd2, 16'h0202);
        drain();

        for (i = 0; i < 9; i++)
        begin
            set_capacity(caps[i]);
            // hold off the receiver while the sender keeps offering
            if (i == 0 || i == 4)
                holds_asked++;
            random_phase(60);
            // pause the sender until every response is in
            drain();
        end

        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/tb_sorted_priority_queue.sv
